>>> src/bpe_pkg.sv
// Shared types and constants for the bit-plane extraction packer.
// No dependencies; imported by bpe_front, bpe_back and the top level.
package bpe_pkg;

  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF   = 2;
  localparam int NUM_SLOTS       = 4;

  // Channel positions inside the pixel word.
  localparam int ALPHA_LSB = 24;
  localparam int RED_LSB   = 16;
  localparam int GREEN_LSB = 8;
  localparam int BLUE_LSB  = 0;

  typedef enum logic [2:0] {
    REG_ALPHA_MASK    = 3'd0,
    REG_RED_MASK      = 3'd1,
    REG_GREEN_MASK    = 3'd2,
    REG_BLUE_MASK     = 3'd3,
    REG_LSB_FIRST     = 3'd4,
    REG_CHANNEL_ORDER = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ORD_RGB = 3'd0,
    ORD_RBG = 3'd1,
    ORD_GBR = 3'd2,
    ORD_GRB = 3'd3,
    ORD_BRG = 3'd4,
    ORD_BGR = 3'd5
  } ord_t;

  typedef enum logic [2:0] {
    STEP_A   = 3'd0,
    STEP_C1  = 3'd1,
    STEP_C2  = 3'd2,
    STEP_C3  = 3'd3,
    STEP_PAD = 3'd4
  } step_t;

  typedef struct packed {
    logic [7:0] alpha_mask;
    logic [7:0] red_mask;
    logic [7:0] green_mask;
    logic [7:0] blue_mask;
    logic       lsb_first;
    logic [2:0] channel_order;
  } cfg_t;

  // One channel's selected bits, first emitted bit in bit 7.
  typedef struct packed {
    logic [7:0] bits;
    logic [3:0] cnt;
  } slot_t;

  typedef struct packed {
    slot_t [NUM_SLOTS-1:0] slot;
    logic                  fe;
  } entry_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } res_t;

  typedef struct packed {
    logic       head_pop;
    logic       out_push;
    logic [2:0] level;
  } bk_ctl_t;

endpackage

>>> src/bpe_fifo.sv
// Small synchronous queue of register slots, used between front and back
// and in front of the result ports. Depends on nothing but its parameters.
module bpe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, wr_ptr_next;
  logic [PW-1:0]    rd_ptr, rd_ptr_next;
  logic [CW-1:0]    count, count_next;
  logic             do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> src/bpe_front.sv
// Front end: splits a pixel into alpha and the ordered colour channels and
// compacts the masked bits of each. Depends on bpe_pkg.
module bpe_front
  import bpe_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [31:0] pixel_word,
  input  logic        frame_end,
  output entry_t      entry
);

  // Gather the enabled bits in walk order, first one into bit 7.
  function automatic slot_t compact(logic [7:0] v, logic [7:0] m, logic lsb);
    slot_t      r;
    logic [3:0] idx;
    logic [2:0] pos;
    r.bits = '0;
    idx    = '0;
    for (int j = 0; j < 8; j++) begin
      pos = lsb ? 3'(j) : 3'(7 - j);
      if (m[pos]) begin
        r.bits[3'd7 - idx[2:0]] = v[pos];
        idx = idx + 4'd1;
      end
    end
    r.cnt = idx;
    return r;
  endfunction

  logic [7:0] a_v, r_v, g_v, b_v;
  slot_t      a_s, r_s, g_s, b_s;

  assign a_v = pixel_word[ALPHA_LSB +: 8];
  assign r_v = pixel_word[RED_LSB   +: 8];
  assign g_v = pixel_word[GREEN_LSB +: 8];
  assign b_v = pixel_word[BLUE_LSB  +: 8];

  assign a_s = compact(a_v, cfg.alpha_mask, cfg.lsb_first);
  assign r_s = compact(r_v, cfg.red_mask,   cfg.lsb_first);
  assign g_s = compact(g_v, cfg.green_mask, cfg.lsb_first);
  assign b_s = compact(b_v, cfg.blue_mask,  cfg.lsb_first);

  always_comb begin
    entry.fe      = frame_end;
    entry.slot[0] = a_s;
    case (ord_t'(cfg.channel_order))
      ORD_RGB: begin
        entry.slot[1] = r_s; entry.slot[2] = g_s; entry.slot[3] = b_s;
      end
      ORD_RBG: begin
        entry.slot[1] = r_s; entry.slot[2] = b_s; entry.slot[3] = g_s;
      end
      ORD_GBR: begin
        entry.slot[1] = g_s; entry.slot[2] = b_s; entry.slot[3] = r_s;
      end
      ORD_GRB: begin
        entry.slot[1] = g_s; entry.slot[2] = r_s; entry.slot[3] = b_s;
      end
      ORD_BRG: begin
        entry.slot[1] = b_s; entry.slot[2] = r_s; entry.slot[3] = g_s;
      end
      ORD_BGR: begin
        entry.slot[1] = b_s; entry.slot[2] = g_s; entry.slot[3] = r_s;
      end
      default: begin
        // Unknown order: alpha only.
        entry.slot[1] = '0; entry.slot[2] = '0; entry.slot[3] = '0;
      end
    endcase
  end

endmodule

>>> src/bpe_back.sv
// Back end: while a pixel waits and the result queue has room, merges one channel slot a cycle
// into the bit accumulator and emits completed bytes, plus the padded byte at frame end. Uses bpe_pkg.
module bpe_back
  import bpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  entry_t  head,
  input  logic    head_valid,
  input  logic    out_full,
  output res_t    res,
  output bk_ctl_t ctl
);

  step_t      step, step_next;
  logic [6:0] acc, acc_next;
  logic [2:0] cnt, cnt_next;

  slot_t       cur;
  logic [14:0] w;
  logic [3:0]  t;
  logic [14:0] wsh;
  logic [14:0] pad_w;
  logic [5:0]  rest;
  logic [5:0]  rem;
  logic        go;
  logic        emit;
  logic        ch_last;

  always_comb begin
    cur   = head.slot[step[1:0]];
    w     = (15'(acc) << cur.cnt) | (15'(cur.bits) >> (4'd8 - cur.cnt));
    t     = 4'(cnt) + cur.cnt;
    wsh   = w >> t[2:0];
    emit  = t[3];
    pad_w = 15'(acc) << (4'd8 - 4'(cnt));
    rest  = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (k > int'(step[1:0])) begin
        rest = rest + 6'(head.slot[k].cnt);
      end
    end
    rem     = rest + 6'(t[2:0]);
    ch_last = (rem < 6'd8) && !(head.fe && (rem != '0));
    go      = head_valid && !out_full;

    step_next    = step;
    acc_next     = acc;
    cnt_next     = cnt;
    ctl.head_pop = 1'b0;
    ctl.out_push = 1'b0;
    ctl.level    = cnt;
    res.data     = wsh[7:0];
    res.last     = ch_last;
    res.done     = ch_last && head.fe;

    case (step)
      STEP_A, STEP_C1, STEP_C2, STEP_C3: begin
        if (go) begin
          ctl.out_push = emit;
          acc_next     = w[6:0] & ~(7'h7f << t[2:0]);
          cnt_next     = t[2:0];
          if (step == STEP_C3) begin
            if (head.fe && (t[2:0] != '0)) begin
              step_next = STEP_PAD;
            end else begin
              ctl.head_pop = 1'b1;
              step_next    = STEP_A;
            end
          end else begin
            step_next = step_t'(step + 3'd1);
          end
        end
      end
      STEP_PAD: begin
        res.data = pad_w[7:0];
        res.last = 1'b1;
        res.done = 1'b1;
        if (go) begin
          ctl.out_push = 1'b1;
          ctl.head_pop = 1'b1;
          acc_next     = '0;
          cnt_next     = '0;
          step_next    = STEP_A;
        end
      end
      default: step_next = STEP_A;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_A;
      acc  <= '0;
      cnt  <= '0;
    end else begin
      step <= step_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

endmodule

>>> src/bit_plane_extract_packer.sv
// Top level of the bit-plane extraction packer: config registers, front end,
// pixel queue, back-end packer and result queue. Depends on bpe_pkg and all
// bpe_* modules.
//
//   channel   handshake           payload
//   -------   -----------------   ------------------------------------
//   pixels    push / full         pixel_word[31:0], frame_end
//   results   pop / empty         packed_byte[7:0], run_last, frame_done
//   config    psel/penable/pwrite paddr[4:2] selects reg, pwdata/prdata
//
// The packer takes each pixel one channel slot at a time (alpha, then three
// colour slots), with a pad step when frame end leaves a partial byte; that
// channel-slot loop sets the rate. The front end compacts each pushed pixel
// into a queue of QUEUE_DEPTH entries, so input keeps flowing while bytes
// drain. Results leave through a queue of OUT_DEPTH entries; a full result
// queue stalls only the packer. Synchronous active-high reset clears all
// registers, both queues and the bit accumulator; there is no clearing pass.
module bit_plane_extract_packer
  import bpe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // pixel side
  input  logic              push,
  output logic              full,
  input  logic [31:0]       pixel_word,
  input  logic              frame_end,
  // result side
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        packed_byte,
  output logic              run_last,
  output logic              frame_done,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  entry_t  fr_entry;
  entry_t  head;
  logic    mid_empty;
  res_t    bk_res;
  res_t    out_res;
  logic    out_full;
  bk_ctl_t bk_ctl;
  logic    cfg_wr;

  // Register port: no wait states; decode on the word index.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_ALPHA_MASK:    cfg.alpha_mask    <= pwdata[7:0];
        REG_RED_MASK:      cfg.red_mask      <= pwdata[7:0];
        REG_GREEN_MASK:    cfg.green_mask    <= pwdata[7:0];
        REG_BLUE_MASK:     cfg.blue_mask     <= pwdata[7:0];
        REG_LSB_FIRST:     cfg.lsb_first     <= pwdata[0];
        REG_CHANNEL_ORDER: cfg.channel_order <= pwdata[2:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_ALPHA_MASK:    prdata = DATA_W'(cfg.alpha_mask);
      REG_RED_MASK:      prdata = DATA_W'(cfg.red_mask);
      REG_GREEN_MASK:    prdata = DATA_W'(cfg.green_mask);
      REG_BLUE_MASK:     prdata = DATA_W'(cfg.blue_mask);
      REG_LSB_FIRST:     prdata = DATA_W'(cfg.lsb_first);
      REG_CHANNEL_ORDER: prdata = DATA_W'(cfg.channel_order);
      default:           prdata = '0;
    endcase
  end

  // Classify and compact the pixel in the cycle it arrives.
  bpe_front u_front (
    .cfg        (cfg),
    .pixel_word (pixel_word),
    .frame_end  (frame_end),
    .entry      (fr_entry)
  );

  // Hold compacted pixels until the packer gets to them.
  bpe_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (fr_entry),
    .full  (full),
    .pop   (bk_ctl.head_pop),
    .rdata (head),
    .empty (mid_empty)
  );

  // Advance one channel slot per cycle while a pixel waits and results have room; emit at most one byte per cycle.
  bpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!mid_empty),
    .out_full   (out_full),
    .res        (bk_res),
    .ctl        (bk_ctl)
  );

  // Decouple the packer from result back-pressure.
  bpe_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (bk_ctl.out_push),
    .wdata (bk_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign packed_byte = out_res.data;
  assign run_last    = out_res.last;
  assign frame_done  = out_res.done;

  // The packer never consumes a pixel that is not there.
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    bk_ctl.head_pop |-> !mid_empty)
    else $error("packer popped an empty pixel queue");

  // The packer never pushes into a full result queue.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    bk_ctl.out_push |-> !out_full)
    else $error("packer pushed into a full result queue");

  // Finishing a frame pixel leaves no pending bits behind.
  a_frame_flush: assert property (@(posedge clk) disable iff (rst)
    (bk_ctl.head_pop && head.fe) |=> (bk_ctl.level == '0))
    else $error("bits left pending after frame end");

  // The frame's final byte is always the last byte of its pixel.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> run_last)
    else $error("frame_done without run_last");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for bit_plane_extract_packer: a directed table, then random
// phases under new register settings, every byte checked against typed bytes or a bit packer
// kept here. Depends on bpe_pkg and the RTL under src.
module tb_top
  import bpe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 5;
  localparam int DRAIN_CYCLES  = 64;      // well past the time four queued pixels take to drain
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PIXELS  = 35;
  localparam int MAX_REPORTS   = 10;
  localparam int USE_MODEL     = -1;      // row expectation comes from the bit packer

  // Register indexes past the end of the map, and channel orders past BGR.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam logic [2:0] ORD_SPARE_6 = 3'd6;
  localparam logic [2:0] ORD_SPARE_7 = 3'd7;

  typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_t;

  // One line of the directed table: a register write or a pixel request.
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] value;
    logic        fe;
    int          nexp;    // typed byte count, or USE_MODEL
    logic [39:0] bytes;   // typed bytes, first one in the top used byte
  } stim_row_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              push        = 1'b0;
  logic              full;
  logic [31:0]       pixel_word  = '0;
  logic              frame_end   = 1'b0;
  logic              pop         = 1'b0;
  logic              empty;
  logic [7:0]        packed_byte;
  logic              run_last;
  logic              frame_done;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Bench copy of the packer: registers, pending bits and their count.
  cfg_t       cfg_model;
  logic [6:0] acc_bits;
  logic [2:0] acc_count;
  logic [7:0] fresh_bytes[$];   // bytes made by the pixel just packed
  res_t       bytes_due[$];     // bytes still owed by the block, oldest first

  stim_row_t  plan[$];
  int         err_count  = 0;
  int         pop_hold   = 0;
  longint     cycle_count = 0;
  bit         quiet      = 1'b0;   // last phase: no idling on either side
  bit         sent_since_settle = 1'b0;

  bit_plane_extract_packer dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pixel_word (pixel_word),
    .frame_end  (frame_end),
    .pop        (pop),
    .empty      (empty),
    .packed_byte(packed_byte),
    .run_last   (run_last),
    .frame_done (frame_done),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop: no correct run comes near this many cycles.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- bit packer

  // Append one extracted bit; a full byte goes out with its first bit in bit 7.
  task automatic shift_in(input logic b);
    logic [7:0] v;
    v = {acc_bits, b};
    if (acc_count == 3'd7) begin
      fresh_bytes.push_back(v);
      acc_bits  = '0;
      acc_count = '0;
    end else begin
      acc_bits  = v[6:0];
      acc_count = acc_count + 3'd1;
    end
  endtask

  // Walk one channel in the configured direction, keeping the masked bits.
  task automatic take_channel(input logic [7:0] value, input logic [7:0] mask);
    int pos;
    for (int k = 0; k < 8; k++) begin
      pos = cfg_model.lsb_first ? k : 7 - k;
      if (mask[pos]) shift_in(value[pos]);
    end
  endtask

  // Pack one pixel: alpha, then the colors in order, then pad on frame end.
  task automatic extract_pixel(input logic [31:0] px, input logic fe);
    int         sh[3];
    logic       colors;
    logic [7:0] pad;
    fresh_bytes.delete();
    colors = 1'b1;
    take_channel(px[ALPHA_LSB +: 8], cfg_model.alpha_mask);
    case (cfg_model.channel_order)
      ORD_RGB: sh = '{RED_LSB, GREEN_LSB, BLUE_LSB};
      ORD_RBG: sh = '{RED_LSB, BLUE_LSB, GREEN_LSB};
      ORD_GBR: sh = '{GREEN_LSB, BLUE_LSB, RED_LSB};
      ORD_GRB: sh = '{GREEN_LSB, RED_LSB, BLUE_LSB};
      ORD_BRG: sh = '{BLUE_LSB, RED_LSB, GREEN_LSB};
      ORD_BGR: sh = '{BLUE_LSB, GREEN_LSB, RED_LSB};
      default: colors = 1'b0;   // unknown order: alpha only
    endcase
    if (colors)
      foreach (sh[k])
        take_channel(px[sh[k] +: 8],
                     sh[k] == RED_LSB   ? cfg_model.red_mask :
                     sh[k] == GREEN_LSB ? cfg_model.green_mask : cfg_model.blue_mask);
    if (fe) begin
      // Pad only when bits are pending; an empty accumulator makes no extra byte.
      if (acc_count != 3'd0) begin
        pad = {1'b0, acc_bits} << (4'd8 - acc_count);
        fresh_bytes.push_back(pad);
      end
      acc_bits  = '0;
      acc_count = '0;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Hold push low until the owed bytes are back and in-flight pixels that make
  // no byte have had time to leave the block.
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sent_since_settle = 1'b0;
  endtask

  // Write a register while the block is idle, then read it back.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want;
    logic        known;
    want  = '0;
    known = 1'b1;
    if (sent_since_settle) settle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    // pready is tied high: the write lands at this edge.
    case (idx)
      REG_ALPHA_MASK: begin
        cfg_model.alpha_mask = val[7:0];
        want = {24'd0, val[7:0]};
      end
      REG_RED_MASK: begin
        cfg_model.red_mask = val[7:0];
        want = {24'd0, val[7:0]};
      end
      REG_GREEN_MASK: begin
        cfg_model.green_mask = val[7:0];
        want = {24'd0, val[7:0]};
      end
      REG_BLUE_MASK: begin
        cfg_model.blue_mask = val[7:0];
        want = {24'd0, val[7:0]};
      end
      REG_LSB_FIRST: begin
        cfg_model.lsb_first = val[0];
        want = {31'd0, val[0]};
      end
      REG_CHANNEL_ORDER: begin
        cfg_model.channel_order = val[2:0];
        want = {29'd0, val[2:0]};
      end
      default: known = 1'b0;   // past the map: nothing changes
    endcase
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (known && prdata !== want)
      flag_error($sformatf("reg %0d readback expected %08h got %08h", idx, want, prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Offer one pixel request, maybe after a random gap, and log the bytes it owes.
  task automatic send_pixel(input logic [31:0] px, input logic fe, input int nexp,
                            input logic [39:0] typed);
    logic [7:0] chosen[$];
    res_t       r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    push       = 1'b1;
    pixel_word = px;
    frame_end  = fe;
    do @(posedge clk); while (full);
    // Accepted at this edge: advance the bench packer in step.
    extract_pixel(px, fe);
    if (nexp == USE_MODEL) chosen = fresh_bytes;
    else
      for (int k = 0; k < nexp; k++) chosen.push_back(typed[8*(nexp-1-k) +: 8]);
    foreach (chosen[k]) begin
      r.data = chosen[k];
      r.last = (k == chosen.size() - 1);
      r.done = r.last && fe;
      bytes_due.push_back(r);
    end
    sent_since_settle = 1'b1;
  endtask

  function automatic void reg_row(input logic [2:0] idx, input logic [31:0] val);
    stim_row_t r;
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.value = val;
    r.fe    = 1'b0;
    r.nexp  = 0;
    r.bytes = '0;
    plan.push_back(r);
  endfunction

  function automatic void pixel_row(input logic [31:0] px, input logic fe, input int nexp,
                                    input logic [39:0] bytes);
    stim_row_t r;
    r.kind  = ROW_PIXEL;
    r.idx   = '0;
    r.value = px;
    r.fe    = fe;
    r.nexp  = nexp;
    r.bytes = bytes;
    plan.push_back(r);
  endfunction

  // Masks lean toward none and all bits, the rest random.
  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- result side

  // Drop pop in random bursts, except in the last phase.
  always @(negedge clk) begin
    if (rst) pop = 1'b0;
    else if (quiet) pop = 1'b1;
    else if (pop_hold > 0) begin
      pop = 1'b0;
      pop_hold--;
    end else begin
      pop = 1'b1;
      if ($urandom_range(0, 7) == 0) pop_hold = $urandom_range(1, 10);
    end
  end

  // Compare each accepted byte with the oldest one owed.
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (bytes_due.size() == 0)
        flag_error($sformatf("byte %02h arrived with nothing owed", packed_byte));
      else begin
        want = bytes_due.pop_front();
        if (packed_byte !== want.data)
          flag_error($sformatf("packed_byte expected %02h got %02h", want.data, packed_byte));
        if (run_last !== want.last)
          flag_error($sformatf("run_last expected %0b got %0b (byte %02h)",
                               want.last, run_last, want.data));
        if (frame_done !== want.done)
          flag_error($sformatf("frame_done expected %0b got %0b (byte %02h)",
                               want.done, frame_done, want.data));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    stim_row_t   row;
    logic [31:0] px;
    logic        fe;
    cfg_model = '0;
    acc_bits  = '0;
    acc_count = '0;

    // Out of reset every mask is clear: a frame end makes no byte at all.
    pixel_row(32'hFFFF_FFFF, 1'b1, 0, '0);
    // All bits, MSB first, RGB: the pixel comes back byte for byte.
    reg_row(REG_ALPHA_MASK, 32'hFF);
    reg_row(REG_RED_MASK, 32'hFF);
    reg_row(REG_GREEN_MASK, 32'hFF);
    reg_row(REG_BLUE_MASK, 32'hFF);
    pixel_row(32'h1234_5678, 1'b0, 4, 40'h12345678);
    // Frame end with nothing pending: the last full byte carries frame_done.
    pixel_row(32'hFFFF_FFFF, 1'b1, 4, 40'hFFFFFFFF);
    pixel_row(32'h0000_0000, 1'b0, 4, 40'h00000000);
    // LSB first mirrors every channel.
    reg_row(REG_LSB_FIRST, 32'd1);
    pixel_row(32'h0180_0FF0, 1'b0, 4, 40'h8001F00F);
    // Colors only, one pixel per channel order other than RGB.
    reg_row(REG_LSB_FIRST, 32'd0);
    reg_row(REG_ALPHA_MASK, 32'h00);
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_RBG));
    pixel_row(32'h0011_2233, 1'b0, 3, 40'h113322);
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_GBR));
    pixel_row(32'h0011_2233, 1'b0, 3, 40'h223311);
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_GRB));
    pixel_row(32'h0011_2233, 1'b0, 3, 40'h221133);
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_BRG));
    pixel_row(32'h0011_2233, 1'b0, 3, 40'h331122);
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_BGR));
    pixel_row(32'h0011_2233, 1'b0, 3, 40'h332211);
    // Unknown orders take alpha only; writes past the map change nothing.
    reg_row(REG_ALPHA_MASK, 32'hFF);
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_SPARE_6));
    pixel_row(32'hAB11_2233, 1'b0, 1, 40'hAB);
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_SPARE_7));
    reg_row(REG_SPARE_6, 32'hFFFF_FFFF);
    reg_row(REG_SPARE_7, 32'hFFFF_FFFF);
    pixel_row(32'h5A77_8899, 1'b1, 1, 40'h5A);
    // One bit per pixel: a pending bit, then a padded byte on frame end.
    reg_row(REG_CHANNEL_ORDER, 32'(ORD_RGB));
    reg_row(REG_ALPHA_MASK, 32'h00);
    reg_row(REG_RED_MASK, 32'h01);
    reg_row(REG_GREEN_MASK, 32'h00);
    reg_row(REG_BLUE_MASK, 32'h00);
    pixel_row(32'h0001_0000, 1'b0, 0, '0);
    pixel_row(32'h0001_0000, 1'b1, 1, 40'hC0);
    // 31 bits per pixel: the second pixel ends with five bytes, the last padded.
    reg_row(REG_ALPHA_MASK, 32'hFF);
    reg_row(REG_RED_MASK, 32'hFF);
    reg_row(REG_GREEN_MASK, 32'hFF);
    reg_row(REG_BLUE_MASK, 32'h7F);
    pixel_row(32'hDEAD_BEEF, 1'b0, USE_MODEL, '0);
    pixel_row(32'hC0FF_EE11, 1'b1, USE_MODEL, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) write_reg(row.idx, row.value);
      else send_pixel(row.value, row.fe, row.nexp, row.bytes);
    end

    // Random phases: new settings each time, random pixels and frame ends.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p == RANDOM_PHASES - 1);
      write_reg(REG_ALPHA_MASK, 32'(pick_mask()));
      write_reg(REG_RED_MASK, 32'(pick_mask()));
      write_reg(REG_GREEN_MASK, 32'(pick_mask()));
      write_reg(REG_BLUE_MASK, 32'(pick_mask()));
      write_reg(REG_LSB_FIRST, $urandom_range(0, 1));
      write_reg(REG_CHANNEL_ORDER, $urandom_range(ORD_RGB, ORD_SPARE_7));
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        case ($urandom_range(0, 15))
          0:       px = '0;
          1:       px = '1;
          default: px = $urandom;
        endcase
        fe = ($urandom_range(0, 9) == 0);
        send_pixel(px, fe, USE_MODEL, '0);
      end
    end

    // Drain what is owed, give stragglers time to show, then report.
    settle();
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
